// ----- sv/lpcm_pkg.sv -----
// lpcm_pkg: shared types and constants for the linear pan channel mixer
`timescale 1ns / 1ps

package lpcm_pkg;

    // channel count of the frame ports
    localparam int MAX_CH      = 8;
    localparam int ROW_W       = $clog2(MAX_CH);
    localparam int COUNT_W     = 4;

    // weights are unsigned, 0..32768 stands for 0.0..1.0
    localparam int WEIGHT_W    = 16;
    localparam int QUO_W       = WEIGHT_W + 1;
    localparam int FRAC_BITS   = 16;
    localparam int STEPS_PER   = 8;
    localparam int RATIO_W     = 6;

    localparam int ROUND_SHIFT = 15;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 4;
    localparam logic [CFG_INDEX_W-1:0] CFG_IN_COUNT   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUT_COUNT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_COMPENSATE = 2'd2;

    // weight rebuild sequencer
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_DIV_HI,
        ST_DIV_LO,
        ST_RUN
    } build_state_t;

    typedef struct packed {
        logic [RATIO_W-1:0] num;
        logic [RATIO_W-1:0] den;
    } ratio_t;

    typedef logic [WEIGHT_W-1:0] weight_t;

endpackage

// ----- sv/linear_pan_channel_mixer.sv -----
// linear_pan_channel_mixer: pipelined 8x8 pan-law mixing matrix with weight rebuild
// done pulses once a frame taken by start has passed stages s0 to s4; one frame per cycle while busy is low, no stall
// weight rebuild after reset or a write to a known register index: 8 rows x 3 states, busy held high
// reset clears counts to 2/2, compensation off, and starts the weight rebuild
// the receiver cannot stall: each result sits on mix_* for the single cycle done is high
`timescale 1ns / 1ps

module linear_pan_channel_mixer #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,

    // frame transfer
    input  logic                                start,
    output logic                                busy,
    input  logic signed [SAMPLE_BITS-1:0]       in_0,
    input  logic signed [SAMPLE_BITS-1:0]       in_1,
    input  logic signed [SAMPLE_BITS-1:0]       in_2,
    input  logic signed [SAMPLE_BITS-1:0]       in_3,
    input  logic signed [SAMPLE_BITS-1:0]       in_4,
    input  logic signed [SAMPLE_BITS-1:0]       in_5,
    input  logic signed [SAMPLE_BITS-1:0]       in_6,
    input  logic signed [SAMPLE_BITS-1:0]       in_7,

    // result transfer
    output logic                                done,
    output logic signed [SAMPLE_BITS-1:0]       mix_0,
    output logic signed [SAMPLE_BITS-1:0]       mix_1,
    output logic signed [SAMPLE_BITS-1:0]       mix_2,
    output logic signed [SAMPLE_BITS-1:0]       mix_3,
    output logic signed [SAMPLE_BITS-1:0]       mix_4,
    output logic signed [SAMPLE_BITS-1:0]       mix_5,
    output logic signed [SAMPLE_BITS-1:0]       mix_6,
    output logic signed [SAMPLE_BITS-1:0]       mix_7,

    // register write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lpcm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lpcm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // datapath widths: product, half-row sum, full sum, rounded value
    localparam int PROD_W  = SAMPLE_BITS + 16;
    localparam int PART_W  = SAMPLE_BITS + 18;
    localparam int ACC_W   = SAMPLE_BITS + 19;
    localparam int RND_W   = ACC_W - lpcm_pkg::ROUND_SHIFT;
    localparam int GROUP   = 4;
    localparam int HALVES  = lpcm_pkg::MAX_CH / GROUP;

    localparam logic signed [ACC_W-1:0] ROUND_HALF =
        ACC_W'(1) << (lpcm_pkg::ROUND_SHIFT - 1);
    localparam logic signed [SAMPLE_BITS-1:0] SAT_MAX =
        {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAT_MIN =
        {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------

    // zero counts behave as one, counts above the port count saturate
    function automatic logic [lpcm_pkg::COUNT_W-1:0] clamp_count(
        input logic [lpcm_pkg::COUNT_W-1:0] n
    );
        logic [lpcm_pkg::COUNT_W-1:0] c;
        c = n;
        if (n == '0)
            c = lpcm_pkg::COUNT_W'(1);
        else if (n > lpcm_pkg::COUNT_W'(lpcm_pkg::MAX_CH))
            c = lpcm_pkg::COUNT_W'(lpcm_pkg::MAX_CH);
        return c;
    endfunction

    // exact weight of input lane i into output row o as num/den (num <= den)
    function automatic lpcm_pkg::ratio_t pan_ratio(
        input logic [lpcm_pkg::COUNT_W-1:0] ni,
        input logic [lpcm_pkg::COUNT_W-1:0] no,
        input logic                         comp,
        input logic [lpcm_pkg::ROW_W-1:0]   o,
        input logic [lpcm_pkg::ROW_W-1:0]   i
    );
        logic [6:0]       n;
        logic [6:0]       m;
        logic [6:0]       a;
        logic [6:0]       b;
        logic [6:0]       t;
        logic [6:0]       d;
        logic [6:0]       num;
        logic [6:0]       den;
        lpcm_pkg::ratio_t r;
        n   = 7'(no) - 7'd1;
        m   = 7'(ni) - 7'd1;
        a   = 7'(7'(i) * n);
        b   = 7'(7'(o) * m);
        t   = 7'({4'b0000, o} << 1);
        d   = '0;
        num = '0;
        den = 7'd1;
        if (7'(o) >= 7'(no) || 7'(i) >= 7'(ni)) begin
            num = '0;
            den = 7'd1;
        end else if (no == lpcm_pkg::COUNT_W'(1)) begin
            num = 7'd1;
            den = 7'd1;
        end else if (ni == lpcm_pkg::COUNT_W'(1)) begin
            // single input sits at the center of the pan range
            d   = (n > t) ? (n - t) : (t - n);
            num = (d >= 7'd2) ? 7'd0 : (7'd2 - d);
            den = 7'd2;
        end else begin
            d   = (a > b) ? (a - b) : (b - a);
            num = (d >= m) ? 7'd0 : (m - d);
            den = m;
        end
        if (comp && (no < ni)) begin
            num = 7'(num * 7'(no));
            den = 7'(den * 7'(ni));
        end
        r.num = num[lpcm_pkg::RATIO_W-1:0];
        r.den = den[lpcm_pkg::RATIO_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------

    logic [lpcm_pkg::COUNT_W-1:0] in_count_reg;
    logic [lpcm_pkg::COUNT_W-1:0] out_count_reg;
    logic                         compensate_reg;
    logic                         cfg_xfer;
    logic                         cfg_hit;
    logic [lpcm_pkg::COUNT_W-1:0] ni_eff;
    logic [lpcm_pkg::COUNT_W-1:0] no_eff;

    // writes are always taken; a known index restarts the weight rebuild
    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign cfg_hit   = cfg_xfer && (cfg_index inside {lpcm_pkg::CFG_IN_COUNT,
                                                      lpcm_pkg::CFG_OUT_COUNT,
                                                      lpcm_pkg::CFG_COMPENSATE});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_count_reg   <= lpcm_pkg::COUNT_W'(2);
            out_count_reg  <= lpcm_pkg::COUNT_W'(2);
            compensate_reg <= 1'b0;
        end
        else if (cfg_xfer)
        begin
            case (cfg_index)
                lpcm_pkg::CFG_IN_COUNT:   in_count_reg   <= cfg_data[lpcm_pkg::COUNT_W-1:0];
                lpcm_pkg::CFG_OUT_COUNT:  out_count_reg  <= cfg_data[lpcm_pkg::COUNT_W-1:0];
                lpcm_pkg::CFG_COMPENSATE: compensate_reg <= cfg_data[0];
                default:                  ;
            endcase
        end
    end

    assign ni_eff = clamp_count(in_count_reg);
    assign no_eff = clamp_count(out_count_reg);

    // ------------------------------------------------------------------
    // weight rebuild sequencer: each output row passes load, divide-high and divide-low,
    // eight lanes divide num/den in parallel, eight quotient bits a cycle
    // ------------------------------------------------------------------

    lpcm_pkg::build_state_t     state_reg;
    lpcm_pkg::build_state_t     state_next;
    logic [lpcm_pkg::ROW_W-1:0] row_reg;
    logic [lpcm_pkg::ROW_W-1:0] row_next;
    logic                       row_load;
    logic                       div_step;
    logic                       row_write;
    logic                       last_row;

    assign last_row = (row_reg == lpcm_pkg::ROW_W'(lpcm_pkg::MAX_CH - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lpcm_pkg::ST_LOAD:   state_next = lpcm_pkg::ST_DIV_HI;
            lpcm_pkg::ST_DIV_HI: state_next = lpcm_pkg::ST_DIV_LO;
            lpcm_pkg::ST_DIV_LO: state_next = last_row ? lpcm_pkg::ST_RUN
                                                       : lpcm_pkg::ST_LOAD;
            lpcm_pkg::ST_RUN:    state_next = lpcm_pkg::ST_RUN;
            default:             state_next = lpcm_pkg::ST_LOAD;
        endcase
        if (cfg_hit)
            state_next = lpcm_pkg::ST_LOAD;
    end

    always_comb
    begin
        row_load  = 1'b0;
        div_step  = 1'b0;
        row_write = 1'b0;
        busy      = 1'b1;
        case (state_reg)
            lpcm_pkg::ST_LOAD:   row_load = 1'b1;
            lpcm_pkg::ST_DIV_HI: div_step = 1'b1;
            lpcm_pkg::ST_DIV_LO:
            begin
                div_step  = 1'b1;
                row_write = 1'b1;
            end
            lpcm_pkg::ST_RUN:    busy = 1'b0;
            default:             ;
        endcase
    end

    always_comb
    begin
        row_next = row_reg;
        if (cfg_hit)
            row_next = '0;
        else if (row_write)
            row_next = row_reg + lpcm_pkg::ROW_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lpcm_pkg::ST_LOAD;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
        end
    end

    // per-lane restoring divider: quotient = floor(num * 2^16 / den)
    logic [lpcm_pkg::RATIO_W-1:0] rem_reg  [lpcm_pkg::MAX_CH];
    logic [lpcm_pkg::RATIO_W-1:0] den_reg  [lpcm_pkg::MAX_CH];
    logic [lpcm_pkg::QUO_W-1:0]   quo_reg  [lpcm_pkg::MAX_CH];
    logic [lpcm_pkg::RATIO_W-1:0] rem_load [lpcm_pkg::MAX_CH];
    logic [lpcm_pkg::RATIO_W-1:0] den_load [lpcm_pkg::MAX_CH];
    logic [lpcm_pkg::QUO_W-1:0]   quo_load [lpcm_pkg::MAX_CH];
    logic [lpcm_pkg::RATIO_W-1:0] rem_step [lpcm_pkg::MAX_CH];
    logic [lpcm_pkg::QUO_W-1:0]   quo_step [lpcm_pkg::MAX_CH];
    lpcm_pkg::weight_t            weight_reg [lpcm_pkg::MAX_CH][lpcm_pkg::MAX_CH];

    always_comb
    begin
        lpcm_pkg::ratio_t rt;
        logic             whole;
        for (int l = 0; l < lpcm_pkg::MAX_CH; l++)
        begin
            rt    = pan_ratio(ni_eff, no_eff, compensate_reg, row_reg,
                              lpcm_pkg::ROW_W'(l));
            // num equal to den is a full-scale weight with no remainder
            whole       = (rt.num == rt.den);
            rem_load[l] = whole ? '0 : rt.num;
            den_load[l] = rt.den;
            quo_load[l] = {{(lpcm_pkg::QUO_W-1){1'b0}}, whole};
        end
    end

    always_comb
    begin
        logic [lpcm_pkg::RATIO_W:0]   r2;
        logic [lpcm_pkg::RATIO_W-1:0] r;
        logic [lpcm_pkg::QUO_W-1:0]   q;
        logic                         qb;
        for (int l = 0; l < lpcm_pkg::MAX_CH; l++)
        begin
            r = rem_reg[l];
            q = quo_reg[l];
            for (int s = 0; s < lpcm_pkg::STEPS_PER; s++)
            begin
                r2 = {r, 1'b0};
                qb = (r2 >= {1'b0, den_reg[l]});
                if (qb)
                    r2 = r2 - {1'b0, den_reg[l]};
                r = r2[lpcm_pkg::RATIO_W-1:0];
                q = {q[lpcm_pkg::QUO_W-2:0], qb};
            end
            rem_step[l] = r;
            quo_step[l] = q;
        end
    end

    always_ff @(posedge clk)
    begin
        logic [lpcm_pkg::QUO_W-1:0] wsum;
        for (int l = 0; l < lpcm_pkg::MAX_CH; l++)
        begin
            if (row_load)
            begin
                rem_reg[l] <= rem_load[l];
                den_reg[l] <= den_load[l];
                quo_reg[l] <= quo_load[l];
            end
            else if (div_step)
            begin
                rem_reg[l] <= rem_step[l];
                quo_reg[l] <= quo_step[l];
            end
            // round half up: (2x quotient + 1) / 2
            wsum = quo_step[l] + lpcm_pkg::QUO_W'(1);
            if (row_write)
                weight_reg[row_reg][l] <= wsum[lpcm_pkg::QUO_W-1:1];
        end
    end

    // ------------------------------------------------------------------
    // mixing pipeline
    //   s0: sample capture
    //   s1: 64 sample x weight products
    //   s2: four-input partial sums per output
    //   s3: full sum per output
    //   s4: round half up, saturate, drive result ports
    // ------------------------------------------------------------------

    logic                          in_xfer;
    logic signed [SAMPLE_BITS-1:0] frame_in [lpcm_pkg::MAX_CH];

    logic                          s0_valid_reg;
    logic                          s1_valid_reg;
    logic                          s2_valid_reg;
    logic                          s3_valid_reg;
    logic                          out_valid_reg;

    logic signed [SAMPLE_BITS-1:0] x_reg    [lpcm_pkg::MAX_CH];
    logic signed [PROD_W-1:0]      prod_next [lpcm_pkg::MAX_CH][lpcm_pkg::MAX_CH];
    logic signed [PROD_W-1:0]      prod_reg  [lpcm_pkg::MAX_CH][lpcm_pkg::MAX_CH];
    logic signed [PART_W-1:0]      part_next [lpcm_pkg::MAX_CH][HALVES];
    logic signed [PART_W-1:0]      part_reg  [lpcm_pkg::MAX_CH][HALVES];
    logic signed [ACC_W-1:0]       acc_next  [lpcm_pkg::MAX_CH];
    logic signed [ACC_W-1:0]       acc_reg   [lpcm_pkg::MAX_CH];
    logic signed [SAMPLE_BITS-1:0] mix_next  [lpcm_pkg::MAX_CH];
    logic signed [SAMPLE_BITS-1:0] mix_reg   [lpcm_pkg::MAX_CH];

    assign in_xfer = start && !busy;

    assign frame_in[0] = in_0;
    assign frame_in[1] = in_1;
    assign frame_in[2] = in_2;
    assign frame_in[3] = in_3;
    assign frame_in[4] = in_4;
    assign frame_in[5] = in_5;
    assign frame_in[6] = in_6;
    assign frame_in[7] = in_7;

    // valid bits travel with the frame; nothing downstream can stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg  <= in_xfer;
            s1_valid_reg  <= s0_valid_reg;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    // unused inputs and outputs carry zero weights, so no extra masking
    always_comb
    begin
        logic signed [SAMPLE_BITS+lpcm_pkg::WEIGHT_W:0] full;
        for (int o = 0; o < lpcm_pkg::MAX_CH; o++)
        begin
            for (int i = 0; i < lpcm_pkg::MAX_CH; i++)
            begin
                full = x_reg[i] * $signed({1'b0, weight_reg[o][i]});
                prod_next[o][i] = full[PROD_W-1:0];
            end
        end
    end

    always_comb
    begin
        for (int o = 0; o < lpcm_pkg::MAX_CH; o++)
        begin
            for (int h = 0; h < HALVES; h++)
            begin
                part_next[o][h] = '0;
                for (int k = 0; k < GROUP; k++)
                    part_next[o][h] = part_next[o][h] + PART_W'(prod_reg[o][GROUP*h+k]);
            end
        end
    end

    always_comb
    begin
        for (int o = 0; o < lpcm_pkg::MAX_CH; o++)
        begin
            acc_next[o] = '0;
            for (int h = 0; h < HALVES; h++)
                acc_next[o] = acc_next[o] + ACC_W'(part_reg[o][h]);
        end
    end

    // floor((sum + 2^14) / 2^15), then clip to the sample range
    always_comb
    begin
        logic signed [ACC_W-1:0] rs;
        logic        [RND_W-1:0] r;
        logic                    sat_hi;
        logic                    sat_lo;
        for (int o = 0; o < lpcm_pkg::MAX_CH; o++)
        begin
            rs     = acc_reg[o] + ROUND_HALF;
            r      = rs[ACC_W-1:lpcm_pkg::ROUND_SHIFT];
            sat_hi = !r[RND_W-1] && (|r[RND_W-2:SAMPLE_BITS-1]);
            sat_lo =  r[RND_W-1] && !(&r[RND_W-2:SAMPLE_BITS-1]);
            if (sat_hi)
                mix_next[o] = SAT_MAX;
            else if (sat_lo)
                mix_next[o] = SAT_MIN;
            else
                mix_next[o] = $signed(r[SAMPLE_BITS-1:0]);
        end
    end

    // payload registers carry no reset; valid bits qualify them
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            x_reg <= frame_in;
        prod_reg <= prod_next;
        part_reg <= part_next;
        acc_reg  <= acc_next;
        mix_reg  <= mix_next;
    end

    // result ports
    assign done  = out_valid_reg;
    assign mix_0 = mix_reg[0];
    assign mix_1 = mix_reg[1];
    assign mix_2 = mix_reg[2];
    assign mix_3 = mix_reg[3];
    assign mix_4 = mix_reg[4];
    assign mix_5 = mix_reg[5];
    assign mix_6 = mix_reg[6];
    assign mix_7 = mix_reg[7];

endmodule

// ----- test/tb_linear_pan_channel_mixer.sv -----
// tb_linear_pan_channel_mixer: scoreboard-checked random and directed test of the pan mixer
`timescale 1ns / 1ps

module tb_linear_pan_channel_mixer;

    localparam int SAMPLE_W    = 16;
    localparam int FRAME_ITEMS = 1750;
    // sender holds off once here until the pipeline is empty
    localparam int HOLD_POINT  = 1200;
    // stretch of frames sent back to back with no gaps
    localparam int QUIET_FIRST = 700;
    localparam int QUIET_LAST  = 1100;
    localparam int STALL_LIMIT = 2000;
    localparam int REPORT_MAX  = 10;
    localparam logic [lpcm_pkg::CFG_INDEX_W-1:0] CFG_NO_REG = 2'd3;

    typedef logic [lpcm_pkg::MAX_CH-1:0][SAMPLE_W-1:0] mix_frame_t;

    // ------------------------------------------------------------------
    // scoreboard: own copy of the registers and weight table, the mixing
    // predictor, and the queue of frames still owed by the block
    // ------------------------------------------------------------------
    class mix_scoreboard;
        int unsigned in_count;
        int unsigned out_count;
        int unsigned compensate;
        int unsigned weight [lpcm_pkg::MAX_CH][lpcm_pkg::MAX_CH];   // [out][in], 32768 is unity
        mix_frame_t  pending_mix [$];
        int          mismatches;

        function new();
            in_count   = 2;
            out_count  = 2;
            compensate = 0;
            mismatches = 0;
            rebuild_weights();
        endfunction

        function int unsigned clamp_count(int unsigned n);
            if (n < 1) return 1;
            if (n > lpcm_pkg::MAX_CH) return lpcm_pkg::MAX_CH;
            return n;
        endfunction

        function void rebuild_weights();
            int unsigned     ni, no, n, m, a, b, d;
            longint unsigned num, den;
            ni = clamp_count(in_count);
            no = clamp_count(out_count);
            for (int o = 0; o < lpcm_pkg::MAX_CH; o++)
            begin
                for (int i = 0; i < lpcm_pkg::MAX_CH; i++)
                begin
                    if (o >= no || i >= ni)
                    begin
                        weight[o][i] = 0;
                        continue;
                    end
                    if (no == 1)
                    begin
                        num = 1;
                        den = 1;
                    end
                    else if (ni == 1)
                    begin
                        // single input sits at the center
                        n   = no - 1;
                        a   = 2 * o;
                        d   = (n > a) ? n - a : a - n;
                        num = (d >= 2) ? 0 : 2 - d;
                        den = 2;
                    end
                    else
                    begin
                        n   = no - 1;
                        m   = ni - 1;
                        a   = i * n;
                        b   = o * m;
                        d   = (a > b) ? a - b : b - a;
                        num = (d >= m) ? 0 : m - d;
                        den = m;
                    end
                    if (compensate != 0 && no < ni)
                    begin
                        num = num * no;
                        den = den * ni;
                    end
                    weight[o][i] = int'((num * 65536 + den) / (2 * den));
                end
            end
        endfunction

        function void write_register(logic [lpcm_pkg::CFG_INDEX_W-1:0] index,
                                     logic [lpcm_pkg::CFG_DATA_W-1:0]  data);
            case (index)
                lpcm_pkg::CFG_IN_COUNT:   in_count   = int'(data);
                lpcm_pkg::CFG_OUT_COUNT:  out_count  = int'(data);
                lpcm_pkg::CFG_COMPENSATE: compensate = int'(data[0]);
                default:                  return;
            endcase
            rebuild_weights();
        endfunction

        function mix_frame_t mix_frame(mix_frame_t samples);
            mix_frame_t mixed;
            longint     acc;
            longint     r;
            for (int o = 0; o < lpcm_pkg::MAX_CH; o++)
            begin
                acc = 0;
                for (int i = 0; i < lpcm_pkg::MAX_CH; i++)
                    acc += longint'($signed(samples[i])) * longint'(weight[o][i]);
                r = (acc + 16384) >>> 15;
                if (r > 32767)  r = 32767;
                if (r < -32768) r = -32768;
                mixed[o] = r[SAMPLE_W-1:0];
            end
            return mixed;
        endfunction

        function void note_frame(mix_frame_t samples);
            pending_mix.push_back(mix_frame(samples));
        endfunction

        function void check_mix(mix_frame_t actual);
            mix_frame_t want;
            if (pending_mix.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("tb: mix frame %h arrived with none pending", actual);
                return;
            end
            want = pending_mix.pop_front();
            for (int k = 0; k < lpcm_pkg::MAX_CH; k++)
            begin
                if (actual[k] !== want[k])
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("tb: mix_%0d expected %0d got %0d (in %0d out %0d comp %0d)",
                                 k, $signed(want[k]), $signed(actual[k]),
                                 in_count, out_count, compensate);
                end
            end
        endfunction

        function int pending_count();
            return pending_mix.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // block ports
    // ------------------------------------------------------------------
    logic                                 clk;
    logic                                 rst_n;
    logic                                 start;
    logic                                 busy;
    logic signed [SAMPLE_W-1:0]           in_0, in_1, in_2, in_3, in_4, in_5, in_6, in_7;
    logic                                 done;
    logic signed [SAMPLE_W-1:0]           mix_0, mix_1, mix_2, mix_3, mix_4, mix_5, mix_6, mix_7;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic [lpcm_pkg::CFG_INDEX_W-1:0]     cfg_index;
    logic [lpcm_pkg::CFG_DATA_W-1:0]      cfg_data;

    mix_frame_t in_bus;
    mix_frame_t mix_bus;

    // element k of a frame is channel k
    assign in_bus  = {in_7, in_6, in_5, in_4, in_3, in_2, in_1, in_0};
    assign mix_bus = {mix_7, mix_6, mix_5, mix_4, mix_3, mix_2, mix_1, mix_0};

    linear_pan_channel_mixer #(
        .SAMPLE_BITS (SAMPLE_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .in_0      (in_0),
        .in_1      (in_1),
        .in_2      (in_2),
        .in_3      (in_3),
        .in_4      (in_4),
        .in_5      (in_5),
        .in_6      (in_6),
        .in_7      (in_7),
        .done      (done),
        .mix_0     (mix_0),
        .mix_1     (mix_1),
        .mix_2     (mix_2),
        .mix_3     (mix_3),
        .mix_4     (mix_4),
        .mix_5     (mix_5),
        .mix_6     (mix_6),
        .mix_7     (mix_7),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mix_scoreboard sb;
    int            frames_sent;
    int            stall_cycles;

    // 4 ns clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // monitor: everything is sampled at the rising edge, before the
    // block and the drivers update, so each transfer is seen exactly once
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            stall_cycles <= 0;
        end
        else
        begin
            // result transfer: done marks a single cycle, no back pressure
            if (done)
                sb.check_mix(mix_bus);
            // frame transfer uses the weights in force at this edge
            if (start && !busy)
                sb.note_frame(in_bus);
            // register transfer rebuilds the predicted weight table
            if (cfg_valid && cfg_ready)
                sb.write_register(cfg_index, cfg_data);

            // watchdog over cycles in which nothing moves at all
            if (done || (start && !busy) || (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // drivers: called at a rising edge, drive with nonblocking writes
    // ------------------------------------------------------------------

    // hold the frame until an edge sees start high and busy low; start is
    // left high so the next frame can follow in the very next cycle
    task automatic send_frame(mix_frame_t samples);
        start <= 1'b1;
        {in_7, in_6, in_5, in_4, in_3, in_2, in_1, in_0} <= samples;
        do @(posedge clk); while (busy);
        frames_sent++;
    endtask

    // one register transfer, then valid is driven low again
    task automatic write_reg(logic [lpcm_pkg::CFG_INDEX_W-1:0] index,
                             logic [lpcm_pkg::CFG_DATA_W-1:0]  data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // stop sending and let every owed frame come back; the first edge
    // lets the monitor note a frame taken at the calling edge
    task automatic drain_frames();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending_count() != 0)
            @(posedge clk);
    endtask

    // random one-cycle sender gaps, none inside the quiet stretch
    task automatic maybe_idle();
        if ((frames_sent < QUIET_FIRST || frames_sent >= QUIET_LAST) &&
            $urandom_range(0, 99) < 10)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // directed sample sets: full scale positive, full scale negative, alternating
    function automatic mix_frame_t edge_frame(int pattern);
        mix_frame_t f;
        for (int k = 0; k < lpcm_pkg::MAX_CH; k++)
        begin
            case (pattern)
                0:       f[k] = 16'h7fff;
                1:       f[k] = 16'h8000;
                default: f[k] = k[0] ? 16'h8000 : 16'h7fff;
            endcase
        end
        return f;
    endfunction

    // mostly full-range noise, with full-scale and near-zero samples mixed in
    function automatic mix_frame_t random_frame();
        mix_frame_t f;
        for (int k = 0; k < lpcm_pkg::MAX_CH; k++)
        begin
            case ($urandom_range(0, 9))
                0:       f[k] = 16'h7fff;
                1:       f[k] = 16'h8000;
                2:       f[k] = 16'($urandom_range(0, 511)) - 16'd256;
                default: f[k] = 16'($urandom);
            endcase
        end
        return f;
    endfunction

    // counts mostly in range, sometimes zero or above the channel limit
    function automatic logic [lpcm_pkg::CFG_DATA_W-1:0] random_count();
        if ($urandom_range(0, 9) == 0)
            return 4'($urandom_range(0, 15));
        return 4'($urandom_range(1, lpcm_pkg::MAX_CH));
    endfunction

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    // directed settings (in_count, out_count, compensate): the reset
    // setting, mono to mono, full downmix that saturates, mono upmix,
    // full matrix with compensation, zero and oversize counts that clamp,
    // and an uneven matrix with a write to the unmapped index
    int dir_in   [8] = '{2, 1, 8, 1, 8, 0, 15, 5};
    int dir_out  [8] = '{2, 1, 1, 8, 8, 15, 3, 7};
    int dir_comp [8] = '{0, 0, 0, 0, 1, 1, 1, 0};

    initial
    begin
        int burst;

        // every input known from time zero while reset is held low
        rst_n       = 1'b0;
        start       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = lpcm_pkg::CFG_IN_COUNT;
        cfg_data    = '0;
        {in_7, in_6, in_5, in_4, in_3, in_2, in_1, in_0} = '0;
        frames_sent = 0;
        sb          = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed part; the first setting runs on the reset weights
        for (int c = 0; c < 8; c++)
        begin
            if (c != 0)
            begin
                drain_frames();
                write_reg(lpcm_pkg::CFG_IN_COUNT,   4'(dir_in[c]));
                write_reg(lpcm_pkg::CFG_OUT_COUNT,  4'(dir_out[c]));
                write_reg(lpcm_pkg::CFG_COMPENSATE, 4'(dir_comp[c]));
                if (c == 7)
                    write_reg(CFG_NO_REG, 4'hf);
            end
            for (int p = 0; p < 3; p++)
                send_frame(edge_frame(p));
        end

        // random part: a new setting per burst, registers written only
        // once the pipeline has emptied, and never inside the quiet stretch
        while (frames_sent < FRAME_ITEMS)
        begin
            if (frames_sent < QUIET_FIRST || frames_sent >= QUIET_LAST)
            begin
                drain_frames();
                if ($urandom_range(0, 3) != 0)
                    write_reg(lpcm_pkg::CFG_IN_COUNT, random_count());
                if ($urandom_range(0, 3) != 0)
                    write_reg(lpcm_pkg::CFG_OUT_COUNT, random_count());
                if ($urandom_range(0, 2) != 0)
                    write_reg(lpcm_pkg::CFG_COMPENSATE, 4'($urandom));
                if ($urandom_range(0, 7) == 0)
                    write_reg(CFG_NO_REG, 4'($urandom));
            end
            burst = $urandom_range(40, 160);
            for (int k = 0; k < burst && frames_sent < FRAME_ITEMS; k++)
            begin
                // hold off once mid-burst until nothing is owed
                if (frames_sent == HOLD_POINT)
                    drain_frames();
                maybe_idle();
                send_frame(random_frame());
            end
        end

        // wait out the pipeline, then wait on for any stray result
        drain_frames();
        repeat (12) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending_count() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/lpcm_pkg.sv
sv/linear_pan_channel_mixer.sv
test/tb_linear_pan_channel_mixer.sv
